[rtl/bwo_pkg.sv]
package bwo_pkg;

    // Field widths
    localparam int CMD_W      = 2;
    localparam int FREQ_W     = 24;
    localparam int IDX_W      = 24;
    localparam int VOL_W      = 7;
    localparam int SR_W       = 18;
    localparam int AMP_W      = 16;
    localparam int SAMPLE_W   = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = SR_W;

    // Stream packing: tdata = {volume, index, frequency}, padded to bytes
    localparam int S_TDATA_W  = ((FREQ_W + IDX_W + VOL_W + 7) / 8) * 8;
    localparam int S_TUSER_W  = CMD_W;
    localparam int M_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;

    // Register reset values
    localparam logic [SR_W-1:0]  SR_RESET  = SR_W'(44100);
    localparam logic [AMP_W-1:0] AMP_RESET = AMP_W'(32768);

    // Phase divider geometry
    localparam int PHASE_BITS   = 24;
    localparam int FREQ_FRAC    = 8;
    localparam int NUM_W        = FREQ_W + IDX_W;
    localparam int DIV_STEPS    = NUM_W + PHASE_BITS - FREQ_FRAC;
    localparam int DIV_STAGES   = (DIV_STEPS + 1) / 2;
    localparam int DIV_W        = 2 * DIV_STAGES;
    localparam logic [PHASE_BITS-1:0] PHASE_HALF = {1'b1, {(PHASE_BITS-1){1'b0}}};

    // Quarter-wave sine table
    localparam int SINE_ENTRIES = 1024;
    localparam int SINE_KW      = $clog2(SINE_ENTRIES);
    localparam int SINE_AW      = SINE_KW + 1;
    localparam int Q15_W        = 16;
    localparam int TRI_W        = 17;
    localparam int WAVE_SW      = 18;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    localparam logic signed [WAVE_SW-1:0] W_POS_ONE = WAVE_SW'(32768);
    localparam logic signed [WAVE_SW-1:0] W_NEG_ONE = -WAVE_SW'(32768);
    localparam logic signed [WAVE_SW-1:0] W_TRI_TOP = WAVE_SW'(98304);

    // Gain and rounding
    localparam int Q15_ONE     = 32768;
    localparam int PCT_FULL    = 100;
    localparam int P1_W        = Q15_W + AMP_W;
    localparam int P2_W        = P1_W + VOL_W;
    localparam int SUM_W       = P2_W + 1;
    localparam int Q15_FRAC    = 15;
    localparam int YF_W        = SUM_W - Q15_FRAC;
    localparam int Y_W         = $clog2(Q15_ONE * PCT_FULL);
    localparam int RECIP_SHIFT = 29;
    localparam int RECIP_W     = 23;
    localparam int PROD_W      = Y_W + RECIP_W;
    localparam logic [SUM_W-1:0]   ROUND_ADD = SUM_W'(Q15_ONE * PCT_FULL / 2);
    localparam logic [YF_W-1:0]    SAT_Y     = YF_W'(Q15_ONE * PCT_FULL);
    localparam logic [RECIP_W-1:0] RECIP     =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(PCT_FULL) - 64'd1) / 64'(PCT_FULL));
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // Codes
    typedef enum logic [CMD_W-1:0] {
        WAVE_SINE     = 0,
        WAVE_SQUARE   = 1,
        WAVE_TRIANGLE = 2,
        WAVE_SAW      = 3
    } t_wave;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_RATE = 0,
        CFG_AMPLITUDE   = 1
    } t_cfg_reg;

    // Side data that rides along the phase divider
    typedef struct packed {
        t_wave            cmd;
        logic [VOL_W-1:0] vol;
    } t_tag;

    // Wave shaper result handed to the gain stages
    typedef struct packed {
        logic [Q15_W-1:0] mag;
        logic             neg;
        logic [VOL_W-1:0] vol;
    } t_wave_res;

    typedef struct packed {
        logic [SR_W-1:0] rem;
        logic            q;
    } t_div_step;

    // One restoring division step
    function automatic t_div_step div_step(input logic [SR_W-1:0] rem,
                                           input logic            din,
                                           input logic [SR_W-1:0] divisor);
        t_div_step   res;
        logic [SR_W:0] x;
        logic [SR_W:0] d;
        x = {rem, din};
        d = {1'b0, divisor};
        if (x >= d) begin
            res.q   = 1'b1;
            res.rem = SR_W'(x - d);
        end else begin
            res.q   = 1'b0;
            res.rem = x[SR_W-1:0];
        end
        return res;
    endfunction

    // Sine table entry: Taylor series in Q30 through theta^15, truncating
    function automatic logic [Q15_W-1:0] sine_entry(input int unsigned idx);
        logic [63:0] theta;
        logic [63:0] th2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        theta = (64'(idx) * HALF_PI_Q30) / 64'(SINE_ENTRIES);
        th2   = (theta * theta) >> 30;
        term  = theta;
        sum   = theta;
        term  = ((term * th2) >> 30) / 64'd6;
        sum   = (sum > term) ? sum - term : 64'd0;
        term  = ((term * th2) >> 30) / 64'd20;
        sum   = sum + term;
        term  = ((term * th2) >> 30) / 64'd42;
        sum   = (sum > term) ? sum - term : 64'd0;
        term  = ((term * th2) >> 30) / 64'd72;
        sum   = sum + term;
        term  = ((term * th2) >> 30) / 64'd110;
        sum   = (sum > term) ? sum - term : 64'd0;
        term  = ((term * th2) >> 30) / 64'd156;
        sum   = sum + term;
        term  = ((term * th2) >> 30) / 64'd210;
        sum   = (sum > term) ? sum - term : 64'd0;
        v     = (sum + 64'd16384) >> 15;
        if (v > 64'(Q15_ONE)) begin
            v = 64'(Q15_ONE);
        end
        return v[Q15_W-1:0];
    endfunction

    typedef logic [Q15_W-1:0] t_sine_rom [0:SINE_ENTRIES];

    function automatic t_sine_rom sine_rom();
        t_sine_rom rom;
        for (int i = 0; i <= SINE_ENTRIES; i++) begin
            rom[i] = sine_entry(i);
        end
        return rom;
    endfunction

endpackage

[rtl/bwo_phase_div.sv]
module bwo_phase_div import bwo_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_vld,
    input  logic [FREQ_W-1:0]     i_freq,
    input  logic [IDX_W-1:0]      i_idx,
    input  t_tag                  i_tag,
    input  logic [SR_W-1:0]       i_sample_rate,
    output logic                  o_vld,
    output logic [PHASE_BITS-1:0] o_phase,
    output t_tag                  o_tag
);

    // Stage registers; stage 0 holds the product
    logic                  r_vld [0:DIV_STAGES];
    t_tag                  r_tag [0:DIV_STAGES];
    logic [PHASE_BITS-1:0] r_quo [0:DIV_STAGES];
    logic [SR_W-1:0]       r_rem [0:DIV_STAGES-1];
    logic [DIV_W-1:0]      r_dvd [0:DIV_STAGES-1];

    logic [NUM_W-1:0] num;

    assign num = NUM_W'(i_freq) * NUM_W'(i_idx);

    // Product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag[0] <= i_tag;
            r_quo[0] <= '0;
            r_rem[0] <= '0;
            r_dvd[0] <= DIV_W'(num) << (PHASE_BITS - FREQ_FRAC);
        end
    end

    // Long division by the sample rate, two quotient bits per stage.
    // The low PHASE_BITS quotient bits are the phase fraction.
    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        t_div_step st_a;
        t_div_step st_b;

        always_comb begin
            st_a = div_step(r_rem[s], r_dvd[s][DIV_W-1], i_sample_rate);
            st_b = div_step(st_a.rem, r_dvd[s][DIV_W-2], i_sample_rate);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[s+1] <= r_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag[s+1] <= r_tag[s];
                r_quo[s+1] <= {r_quo[s][PHASE_BITS-3:0], st_a.q, st_b.q};
            end
        end

        if (s < DIV_STAGES - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s+1] <= st_b.rem;
                    r_dvd[s+1] <= r_dvd[s] << 2;
                end
            end
        end
    end

    assign o_vld   = r_vld[DIV_STAGES];
    assign o_phase = r_quo[DIV_STAGES];
    assign o_tag   = r_tag[DIV_STAGES];

endmodule

[rtl/bwo_wave.sv]
module bwo_wave import bwo_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_vld,
    input  logic [PHASE_BITS-1:0] i_phase,
    input  t_tag                  i_tag,
    input  logic                  i_rate_zero,
    output logic                  o_vld,
    output t_wave_res             o_res
);

    localparam t_sine_rom SINE_ROM = sine_rom();

    logic [PHASE_BITS-1:0]         p;
    logic [1:0]                    quad;
    logic [PHASE_BITS+SINE_KW-3:0] k_ext;
    logic [SINE_KW-1:0]            k;
    logic [SINE_AW-1:0]            addr;
    logic [PHASE_BITS+TRI_W-1:0]   tri_ext;
    logic [TRI_W-1:0]              a;
    logic signed [WAVE_SW-1:0]     w;
    logic signed [WAVE_SW-1:0]     w_abs;

    // First stage: registers
    logic               r1_vld;
    logic [SINE_AW-1:0] r1_addr;
    logic               r1_qneg;
    logic               r1_sine;
    logic [Q15_W-1:0]   r1_mag;
    logic               r1_neg;
    logic [VOL_W-1:0]   r1_vol;

    // Second stage: registers
    logic               r2_vld;
    logic [Q15_W-1:0]   r2_rom;
    logic               r2_qneg;
    logic               r2_sine;
    logic [Q15_W-1:0]   r2_mag;
    logic               r2_neg;
    logic [VOL_W-1:0]   r2_vol;

    // Table address from quadrant and offset
    always_comb begin
        p       = i_rate_zero ? '0 : i_phase;
        quad    = p[PHASE_BITS-1:PHASE_BITS-2];
        k_ext   = {p[PHASE_BITS-3:0], {SINE_KW{1'b0}}};
        k       = k_ext[PHASE_BITS+SINE_KW-3:PHASE_BITS-2];
        addr    = quad[0] ? (SINE_AW'(SINE_ENTRIES) - {1'b0, k}) : {1'b0, k};
        tri_ext = {p, {TRI_W{1'b0}}};
        a       = tri_ext[PHASE_BITS+TRI_W-1:PHASE_BITS];
    end

    // Square, triangle and sawtooth as signed Q15
    always_comb begin
        unique case (i_tag.cmd)
            WAVE_SINE: begin
                w = '0;
            end
            WAVE_SQUARE: begin
                w = (p <= PHASE_HALF) ? W_POS_ONE : W_NEG_ONE;
            end
            WAVE_TRIANGLE: begin
                w = a[TRI_W-1] ? (W_TRI_TOP - signed'({1'b0, a}))
                               : (signed'({1'b0, a}) - W_POS_ONE);
            end
            WAVE_SAW: begin
                w = signed'({2'b00, a[TRI_W-1:1]}) - W_POS_ONE;
            end
        endcase
        w_abs = w[WAVE_SW-1] ? -w : w;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_addr <= addr;
            r1_qneg <= quad[1];
            r1_sine <= (i_tag.cmd == WAVE_SINE);
            r1_mag  <= w_abs[Q15_W-1:0];
            r1_neg  <= w[WAVE_SW-1];
            r1_vol  <= i_tag.vol;
        end
    end

    // Table read
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_rom  <= SINE_ROM[r1_addr];
            r2_qneg <= r1_qneg;
            r2_sine <= r1_sine;
            r2_mag  <= r1_mag;
            r2_neg  <= r1_neg;
            r2_vol  <= r1_vol;
        end
    end

    assign o_vld     = r2_vld;
    assign o_res.mag = r2_sine ? r2_rom : r2_mag;
    assign o_res.neg = r2_sine ? r2_qneg : r2_neg;
    assign o_res.vol = r2_vol;

endmodule

[rtl/bwo_scale.sv]
module bwo_scale import bwo_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_vld,
    input  t_wave_res                  i_res,
    input  logic [AMP_W-1:0]           i_amplitude,
    output logic                       o_vld,
    output logic signed [SAMPLE_W-1:0] o_sample
);

    logic               r1_vld;
    logic [P1_W-1:0]    r1_prod;
    logic               r1_neg;
    logic [VOL_W-1:0]   r1_vol;

    logic               r2_vld;
    logic [P2_W-1:0]    r2_prod;
    logic               r2_neg;

    logic               r3_vld;
    logic [Y_W-1:0]     r3_y;
    logic               r3_sat;
    logic               r3_neg;

    logic               r4_vld;
    logic [PROD_W-1:0]  r4_prod;
    logic               r4_sat;
    logic               r4_neg;

    logic [SUM_W-1:0]    sum;
    logic [YF_W-1:0]     y_full;
    logic [SAMPLE_W-1:0] q;

    // Rounded product scaled down by 2^15, then compared with the clip point
    assign sum    = SUM_W'(r2_prod) + ROUND_ADD;
    assign y_full = sum[SUM_W-1:Q15_FRAC];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // level times amplitude
            r1_prod <= P1_W'(i_res.mag) * P1_W'(i_amplitude);
            r1_neg  <= i_res.neg;
            r1_vol  <= i_res.vol;
            // times volume
            r2_prod <= P2_W'(r1_prod) * P2_W'(r1_vol);
            r2_neg  <= r1_neg;
            // round and clip check
            r3_y    <= y_full[Y_W-1:0];
            r3_sat  <= (y_full >= SAT_Y);
            r3_neg  <= r2_neg;
            // divide by 100 through the reciprocal
            r4_prod <= PROD_W'(r3_y) * PROD_W'(RECIP);
            r4_sat  <= r3_sat;
            r4_neg  <= r3_neg;
        end
    end

    // Sign and saturation
    assign q = r4_prod[RECIP_SHIFT +: SAMPLE_W];

    always_comb begin
        if (r4_sat) begin
            o_sample = r4_neg ? SAMPLE_MIN : SAMPLE_MAX;
        end else begin
            o_sample = r4_neg ? -signed'(q) : signed'(q);
        end
    end

    assign o_vld = r4_vld;

endmodule

[rtl/bwo_out_buf.sv]
module bwo_out_buf import bwo_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_vld,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_ready,
    output logic                       o_en,
    output logic                       o_vld,
    output logic signed [SAMPLE_W-1:0] o_sample
);

    logic                       r_out_vld;
    logic signed [SAMPLE_W-1:0] r_out;
    logic                       r_skid_vld;
    logic signed [SAMPLE_W-1:0] r_skid;

    logic                       n_out_vld;
    logic                       n_skid_vld;
    logic                       load_out;
    logic                       load_skid;
    logic                       take;
    logic                       push;

    // Pipeline runs while the skid slot is free
    assign o_en = !r_skid_vld;
    assign take = r_out_vld && i_ready;
    assign push = o_en && i_vld;

    always_comb begin
        n_out_vld  = r_out_vld;
        n_skid_vld = r_skid_vld;
        load_out   = 1'b0;
        load_skid  = 1'b0;
        if (r_skid_vld) begin
            if (take) begin
                n_skid_vld = 1'b0;
            end
        end else if (push) begin
            if (!r_out_vld || take) begin
                load_out  = 1'b1;
                n_out_vld = 1'b1;
            end else begin
                load_skid  = 1'b1;
                n_skid_vld = 1'b1;
            end
        end else if (take) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= i_sample;
        end else if (r_skid_vld && take) begin
            r_out <= r_skid;
        end
        if (load_skid) begin
            r_skid <= i_sample;
        end
    end

    assign o_vld    = r_out_vld;
    assign o_sample = r_out;

endmodule

[rtl/basic_waveform_oscillator_unit.sv]
// Path from an accepted input word to the result word on o_m_axis_tvalid:
//   one product stage, 32 phase divider stages (two quotient bits each),
//   two wave/table stages, four gain stages, then the output register.
// Throughput: one word per cycle while the two-entry output buffer has room.
// Reset (synchronous, i_rst_n low) clears all valid bits and loads
//   sample_rate = 44100 and amplitude = 32768; no memory clearing is needed.
module basic_waveform_oscillator_unit import bwo_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [23:0] frequency, [47:24] sample_index, [54:48] volume_percent, [55] zero
    input  logic [S_TDATA_W-1:0]  i_s_axis_tdata,
    // [1:0] cmd
    input  logic [S_TUSER_W-1:0]  i_s_axis_tuser,
    // Output stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [15:0] sample
    output logic [M_TDATA_W-1:0]  o_m_axis_tdata,
    // Register write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [SR_W-1:0]  r_sample_rate;
    logic [AMP_W-1:0] r_amplitude;

    logic                       en;
    logic                       accept;
    t_tag                       in_tag;
    logic                       div_vld;
    logic [PHASE_BITS-1:0]      div_phase;
    t_tag                       div_tag;
    logic                       wave_vld;
    t_wave_res                  wave_res;
    logic                       scale_vld;
    logic signed [SAMPLE_W-1:0] scale_sample;
    logic signed [SAMPLE_W-1:0] out_sample;

    // Register writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_rate <= SR_RESET;
            r_amplitude   <= AMP_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_SAMPLE_RATE: r_sample_rate <= i_cfg_data[SR_W-1:0];
                CFG_AMPLITUDE:   r_amplitude   <= i_cfg_data[AMP_W-1:0];
            endcase
        end
    end

    // Input word
    assign o_s_axis_tready = en;
    assign accept          = i_s_axis_tvalid && en;
    assign in_tag.cmd      = t_wave'(i_s_axis_tuser[CMD_W-1:0]);
    assign in_tag.vol      = i_s_axis_tdata[FREQ_W+IDX_W +: VOL_W];

    bwo_phase_div u_phase_div (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_vld         (accept),
        .i_freq        (i_s_axis_tdata[0 +: FREQ_W]),
        .i_idx         (i_s_axis_tdata[FREQ_W +: IDX_W]),
        .i_tag         (in_tag),
        .i_sample_rate (r_sample_rate),
        .o_vld         (div_vld),
        .o_phase       (div_phase),
        .o_tag         (div_tag)
    );

    bwo_wave u_wave (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_vld       (div_vld),
        .i_phase     (div_phase),
        .i_tag       (div_tag),
        .i_rate_zero (r_sample_rate == '0),
        .o_vld       (wave_vld),
        .o_res       (wave_res)
    );

    bwo_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_vld       (wave_vld),
        .i_res       (wave_res),
        .i_amplitude (r_amplitude),
        .o_vld       (scale_vld),
        .o_sample    (scale_sample)
    );

    bwo_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (scale_vld),
        .i_sample (scale_sample),
        .i_ready  (i_m_axis_tready),
        .o_en     (en),
        .o_vld    (o_m_axis_tvalid),
        .o_sample (out_sample)
    );

    assign o_m_axis_tdata = M_TDATA_W'(unsigned'(out_sample));

endmodule

[rtl/bwo_checker.sv]
module bwo_checker import bwo_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_s_axis_tready,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [M_TDATA_W-1:0]  o_m_axis_tdata
);

    // A stalled result word stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output word dropped while stalled");

    // ... and keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("output word changed while stalled");

    // Reset empties the output side
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // Input only backs off when a result is held and was stalled last cycle
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid &&
                             $past(o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input stalled without output backpressure");

endmodule

bind basic_waveform_oscillator_unit bwo_checker u_bwo_checker (.*);

[dv/basic_waveform_oscillator_unit_tb.sv]
`timescale 1ns / 1ps

module basic_waveform_oscillator_unit_tb import bwo_pkg::*; ();

    localparam int DRAIN_CYCLES = 45;    // pipeline depth plus output buffer, with margin
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
    localparam int STALL_LIMIT  = 4000;  // cycles without any handshake

    // Tone generator predictor and in-order sample checker
    class tone_scoreboard;
        logic [SR_W-1:0]            rate;
        logic [AMP_W-1:0]           gain;
        logic [Q15_W-1:0]           quarter_sine [0:SINE_ENTRIES];
        logic signed [SAMPLE_W-1:0] pending_samples [$];
        int unsigned                n_requests;
        int unsigned                n_checked;
        int unsigned                n_bad;

        function new();
            longint unsigned ang;
            longint unsigned ang2;
            longint unsigned t;
            longint unsigned acc;
            longint unsigned v;
            rate       = SR_RESET;
            gain       = AMP_RESET;
            n_requests = 0;
            n_checked  = 0;
            n_bad      = 0;
            // quarter-wave sine: odd Taylor terms in Q30, truncated at each step
            for (int i = 0; i <= SINE_ENTRIES; i++) begin
                ang  = (64'(i) * HALF_PI_Q30) / 64'(SINE_ENTRIES);
                ang2 = (ang * ang) >> 30;
                t    = ang;
                acc  = ang;
                for (int n = 1; n <= 7; n++) begin
                    t = ((t * ang2) >> 30) / 64'((2 * n) * (2 * n + 1));
                    if (n % 2 == 1) begin
                        acc = (acc > t) ? acc - t : 64'd0;
                    end else begin
                        acc = acc + t;
                    end
                end
                v = (acc + 64'd16384) >> 15;
                if (v > 64'd32768) begin
                    v = 64'd32768;
                end
                quarter_sine[i] = v[Q15_W-1:0];
            end
        endfunction

        function void set_register(t_cfg_reg r, logic [CFG_DATA_W-1:0] d);
            case (r)
                CFG_SAMPLE_RATE: rate = d[SR_W-1:0];
                CFG_AMPLITUDE:   gain = d[AMP_W-1:0];
                default:         ;
            endcase
        endfunction

        // fraction of freq * index / (rate * 256); zero rate gives phase zero
        function logic [PHASE_BITS-1:0] tone_phase(logic [FREQ_W-1:0] f,
                                                   logic [IDX_W-1:0] idx);
            longint unsigned span;
            longint unsigned r;
            span = 64'(rate) << FREQ_FRAC;
            if (span == 0) begin
                return '0;
            end
            r = (64'(f) * 64'(idx)) % span;
            return PHASE_BITS'((r << PHASE_BITS) / span);
        endfunction

        // unscaled wave level, 32768 = 1.0
        function longint wave_level(t_wave w, logic [PHASE_BITS-1:0] ph);
            longint unsigned pu;
            longint unsigned step;
            logic [1:0]      quad;
            longint          a;
            longint          lvl;
            pu = 64'(ph);
            case (w)
                WAVE_SINE: begin
                    quad = ph[PHASE_BITS-1 -: 2];
                    step = ((pu & ((64'd1 << (PHASE_BITS - 2)) - 1)) * SINE_ENTRIES)
                           >> (PHASE_BITS - 2);
                    lvl  = quad[0] ? longint'(quarter_sine[SINE_ENTRIES - step])
                                   : longint'(quarter_sine[step]);
                    if (quad[1]) begin
                        lvl = -lvl;
                    end
                end
                WAVE_SQUARE: begin
                    lvl = (ph <= PHASE_HALF) ? 32768 : -32768;
                end
                WAVE_TRIANGLE: begin
                    a   = longint'((pu * 64'd131072) >> PHASE_BITS);
                    lvl = (ph < PHASE_HALF) ? a - 32768 : 98304 - a;
                end
                default: begin
                    lvl = longint'((pu * 64'd65536) >> PHASE_BITS) - 32768;
                end
            endcase
            return lvl;
        endfunction

        // accepted request: predict its sample
        function void note_request(t_wave w, logic [FREQ_W-1:0] f,
                                   logic [IDX_W-1:0] idx, logic [VOL_W-1:0] vol);
            longint          lvl;
            longint unsigned mag;
            longint unsigned q;
            logic signed [SAMPLE_W-1:0] s;
            lvl = wave_level(w, tone_phase(f, idx));
            mag = (lvl < 0) ? longint'(-lvl) : longint'(lvl);
            // gain = amplitude * vol / (32768 * 100), round half away from zero
            q = (mag * 64'(gain) * 64'(vol) + 64'(Q15_ONE * PCT_FULL / 2))
                / 64'(Q15_ONE * PCT_FULL);
            if (lvl < 0) begin
                s = (q > 64'd32768) ? SAMPLE_MIN : SAMPLE_W'(-longint'(q));
            end else begin
                s = (q > 64'd32767) ? SAMPLE_MAX : SAMPLE_W'(q);
            end
            pending_samples = {pending_samples, s};
            n_requests++;
        endfunction

        function void report_bad(string what);
            n_bad++;
            if (n_bad <= 10) begin
                $display("[%0t] %s", $time, what);
            end
        endfunction

        function void check_sample(logic signed [SAMPLE_W-1:0] got);
            logic signed [SAMPLE_W-1:0] want;
            if (pending_samples.size() == 0) begin
                report_bad($sformatf("unexpected sample %0d", got));
                return;
            end
            want = pending_samples.pop_front();
            n_checked++;
            if (got !== want) begin
                report_bad($sformatf("sample %0d: expected %0d, got %0d",
                                     n_checked - 1, want, got));
            end
        endfunction

        function int pending();
            return pending_samples.size();
        endfunction

        function void close_out();
            if (pending_samples.size() != 0) begin
                report_bad($sformatf("%0d samples never arrived", pending_samples.size()));
            end
        endfunction
    endclass

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [S_TDATA_W-1:0]  i_s_axis_tdata  = '0;
    logic [S_TUSER_W-1:0]  i_s_axis_tuser  = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  o_m_axis_tdata;
    logic                  i_cfg_valid     = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;

    tone_scoreboard sb = new();

    int unsigned send_idle_pct = 26;
    int unsigned recv_idle_pct = 88;
    bit          hold_request  = 1'b0;
    int unsigned hold_left     = 0;
    int unsigned n_settings    = 1;

    basic_waveform_oscillator_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Receiver: random back-pressure, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitors: check result words, predict on accepted request words
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            sb.check_sample(o_m_axis_tdata[SAMPLE_W-1:0]);
        end
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            sb.note_request(t_wave'(i_s_axis_tuser), i_s_axis_tdata[FREQ_W-1:0],
                            i_s_axis_tdata[FREQ_W +: IDX_W],
                            i_s_axis_tdata[FREQ_W + IDX_W +: VOL_W]);
        end
    end

    // Watchdog: no handshake of any kind for too long
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("watchdog: no progress for %0d cycles, %0d samples outstanding",
                 STALL_LIMIT, sb.pending());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // One request word; valid stays high afterwards unless the next call idles
    task automatic send_tone(input t_wave w, input logic [FREQ_W-1:0] f,
                             input logic [IDX_W-1:0] idx, input logic [VOL_W-1:0] vol);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {1'b0, vol, idx, f};
        i_s_axis_tuser  <= w;
        @(posedge i_clk);
        while (!o_s_axis_tready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic drain();
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Both registers, back to back, valid held high across the pair
    task automatic configure(input logic [CFG_DATA_W-1:0] rate,
                             input logic [CFG_DATA_W-1:0] amp);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_SAMPLE_RATE;
        i_cfg_data  <= rate;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        sb.set_register(CFG_SAMPLE_RATE, rate);
        i_cfg_index <= CFG_AMPLITUDE;
        i_cfg_data  <= amp;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        sb.set_register(CFG_AMPLITUDE, amp);
        i_cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // Random tones under one register setting and one idling pattern
    task automatic run_setting(input logic [CFG_DATA_W-1:0] rate,
                               input logic [CFG_DATA_W-1:0] amp,
                               input int unsigned s_pct, input int unsigned r_pct,
                               input int unsigned n_tones, input bit squeeze);
        logic [FREQ_W-1:0] f;
        logic [IDX_W-1:0]  idx;
        logic [VOL_W-1:0]  vol;
        drain();
        configure(rate, amp);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        if (squeeze) begin
            hold_request = 1'b1;
        end
        repeat (n_tones) begin
            case ($urandom_range(2))
                0:       f = FREQ_W'($urandom);
                1:       f = FREQ_W'($urandom_range(20 * 256, 20000 * 256));
                default: f = FREQ_W'($urandom_range(255));
            endcase
            idx = ($urandom_range(1) == 0) ? IDX_W'($urandom)
                                            : IDX_W'($urandom_range(200000));
            vol = ($urandom_range(4) == 0) ? VOL_W'($urandom_range(101, 127))
                                            : VOL_W'($urandom_range(100));
            send_tone(t_wave'($urandom_range(3)), f, idx, vol);
        end
        i_s_axis_tvalid <= 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: phase at 0, 1/4, 1/2, 3/4 of a cycle at the reset rate,
        // all-ones fields with volume above 100, then a few odd corners
        for (int w = 0; w < 4; w++) begin
            send_tone(t_wave'(w), 24'd0,       24'd0,       7'd100);
            send_tone(t_wave'(w), 24'd2822400, 24'd1,       7'd100);
            send_tone(t_wave'(w), 24'd5644800, 24'd1,       7'd100);
            send_tone(t_wave'(w), 24'd8467200, 24'd1,       7'd100);
            send_tone(t_wave'(w), 24'hFFFFFF,  24'hFFFFFF,  7'd127);
        end
        send_tone(WAVE_SINE,     24'hFFFFFF, 24'hFFFFFF, 7'd0);
        send_tone(WAVE_SQUARE,   24'd5644800, 24'd1,     7'd101);
        send_tone(WAVE_SAW,      24'd1,      24'd1,      7'd1);
        send_tone(WAVE_TRIANGLE, 24'h800000, 24'h800001, 7'd64);
        i_s_axis_tvalid <= 1'b0;

        // sender light, receiver heavy
        run_setting(18'd8000,   {2'b01, 16'd32768}, 26, 88, 350, 1'b0);
        run_setting(18'd192000, 18'd0,              26, 88, 300, 1'b0);
        // sender heavy, receiver light; zero rate and all-ones rate
        run_setting(18'd0,      {2'b10, 16'hFFFF},  88, 26, 300, 1'b0);
        run_setting(18'h3FFFF,  18'd1,              88, 26, 300, 1'b0);
        // no idling; long receiver hold-off fills the pipe
        run_setting(18'd44100,  18'd32767,          0,  0,  300, 1'b1);
        run_setting(18'($urandom_range(8000, 192000)), 18'($urandom_range(32768)),
                    0, 0, 326, 1'b0);

        drain();
        sb.close_out();
        $display("%0d tone requests, all four waves, over %0d register settings",
                 sb.n_requests, n_settings);
        $display("%0d samples checked, %0d mismatches", sb.n_checked, sb.n_bad);
        if (sb.n_bad == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/bwo_pkg.sv
rtl/bwo_phase_div.sv
rtl/bwo_wave.sv
rtl/bwo_scale.sv
rtl/bwo_out_buf.sv
rtl/basic_waveform_oscillator_unit.sv
rtl/bwo_checker.sv
dv/basic_waveform_oscillator_unit_tb.sv
